// ===== rtl/bqds_pkg.sv =====
// ----------------------------------------------------------------------------
// bqds_pkg: shared types for the quotient digit step
// Length width, controller states and the command and status groups
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bqds_pkg;

  localparam int LEN_W = 7;

  typedef enum logic [7:0] {
    S_LOAD = 8'b0000_0001,
    S_EVAL = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_MSUB = 8'b0000_1000,
    S_CMP  = 8'b0001_0000,
    S_SUB  = 8'b0010_0000,
    S_OUT  = 8'b0100_0000,
    S_ERR  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    state_t op;
    logic   first;
  } cmd_t;

  typedef struct packed {
    logic last_acc;
    logic bad;
    logic div_needed;
    logic div_done;
    logic q_zero;
    logic pass_done;
    logic ge;
    logic out_done;
  } status_t;

endpackage

// ===== rtl/bqds_ctrl.sv =====
// ----------------------------------------------------------------------------
// bqds_ctrl: phase sequencer
// Steps through load, check, divide, multiply-subtract, compare, correct
// and result or error phases, and flags the first cycle of each entered phase.
// ----------------------------------------------------------------------------
module bqds_ctrl
  import bqds_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  status_t st,
  output cmd_t    cmd,
  output logic    in_stall
);

  state_t state_r, state_nxt;
  logic   first_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (st.last_acc) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (st.bad) state_nxt = S_ERR;
        else if (st.div_needed) state_nxt = S_DIV;
        else state_nxt = S_OUT;
      end
      S_DIV: begin
        if (st.div_done) state_nxt = st.q_zero ? S_CMP : S_MSUB;
      end
      S_MSUB: begin
        if (st.pass_done) state_nxt = S_CMP;
      end
      S_CMP: begin
        if (st.pass_done) state_nxt = st.ge ? S_SUB : S_OUT;
      end
      S_SUB: begin
        if (st.pass_done) state_nxt = S_OUT;
      end
      S_OUT, S_ERR: begin
        if (st.out_done) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= (state_nxt != state_r);
    end
  end

  assign cmd.op    = state_r;
  assign cmd.first = first_r;
  assign in_stall  = (state_r != S_LOAD);

endmodule

// ===== rtl/bqds_datapath.sv =====
// ----------------------------------------------------------------------------
// bqds_datapath: digit stores, shift-subtract divider and digit passes
// Holds both operands in digit memories, estimates the quotient digit,
// runs the multiply-subtract, compare and correction passes, and drives
// the result register.
// ----------------------------------------------------------------------------
module bqds_datapath
  import bqds_pkg::*;
#(
  parameter int MAX_DIGITS = 64,
  parameter int DIGIT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               st,
  input  logic                  in_valid,
  input  logic [DIGIT_BITS-1:0] in_dividend_digit,
  input  logic [DIGIT_BITS-1:0] in_divisor_digit,
  input  logic [LEN_W-1:0]      in_dividend_len,
  input  logic                  in_last_digit,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIGIT_BITS-1:0] out_quotient,
  output logic [DIGIT_BITS-1:0] out_remainder_digit,
  output logic [LEN_W-1:0]      out_remainder_len,
  output logic                  out_error,
  output logic                  out_last_result
);

  localparam int DB  = DIGIT_BITS;
  localparam int AW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int DCW = $clog2(DIGIT_BITS + 1);
  localparam logic [LEN_W-1:0] MAXC   = LEN_W'(MAX_DIGITS);
  localparam logic [LEN_W-1:0] OVFC   = LEN_W'(MAX_DIGITS + 1);
  localparam logic [DB-1:0]    DMASK  = '1;
  localparam logic [DCW-1:0]   DSTEPS = DCW'(DIGIT_BITS);

  logic [DB-1:0] dvd_mem [MAX_DIGITS];
  logic [DB-1:0] dvs_mem [MAX_DIGITS];
  logic [DB-1:0] dvd_rd_r, dvs_rd_r;

  logic [LEN_W-1:0] cnt_r, slen_r, iss_r, len_r, k_r;
  logic [DB-1:0]    top_dvd_r, top_dvs_r, q_r, rem_r;
  logic [DCW-1:0]   dcnt_r;
  logic [AW-1:0]    idx1_r, idx2_r;
  logic             p1_r, p2_r, bor_r, ge_r, dec_r, found_r, pend_r;
  logic [2*DB-1:0]  prod_r;
  logic [DB-1:0]    dvd2_r, carry_r;

  logic             out_valid_r, out_err_r, out_last_r;
  logic [DB-1:0]    out_quo_r, out_rem_r;
  logic [LEN_W-1:0] out_len_r;

  logic             acc, out_acc, issue, pass_op;
  logic [LEN_W-1:0] cur_len, cmp_pos, iss_pos, k_nxt;
  logic [DB-1:0]    ld_dvd;
  logic [AW-1:0]    raddr, waddr;
  logic             dvd_we, dvs_we;
  logic [DB-1:0]    wdata;
  logic [2*DB-1:0]  t_sum;
  logic [DB:0]      msub_d, sub_d, rem_sh, dvsr, rem_sub;
  logic             div_bit;

  assign acc     = in_valid && (cmd.op == S_LOAD);
  assign out_acc = out_valid_r && !out_stall;
  assign cur_len = (cnt_r == '0) ? in_dividend_len : slen_r;
  assign ld_dvd  = (cnt_r < cur_len) ? in_dividend_digit : '0;

  assign pass_op = (cmd.op == S_MSUB) || (cmd.op == S_CMP) || (cmd.op == S_SUB);
  assign issue   = pass_op && !cmd.first && (iss_r < slen_r);
  assign cmp_pos = slen_r - iss_r - LEN_W'(1);
  assign iss_pos = (cmd.op == S_CMP) ? cmp_pos : iss_r;

  always_comb begin
    if (cmd.first) k_nxt = '0;
    else if (out_acc && !out_last_r) k_nxt = k_r + LEN_W'(1);
    else k_nxt = k_r;
  end

  assign raddr = (cmd.op == S_OUT) ? k_nxt[AW-1:0] : iss_pos[AW-1:0];

  assign t_sum  = prod_r + {{DB{1'b0}}, carry_r};
  assign msub_d = {1'b0, dvd2_r} - {1'b0, t_sum[DB-1:0]} - (DB+1)'(bor_r);
  assign sub_d  = {1'b0, dvd_rd_r} - {1'b0, dvs_rd_r} - (DB+1)'(bor_r);

  assign rem_sh  = {rem_r, q_r[DB-1]};
  assign dvsr    = {1'b0, top_dvs_r} + (DB+1)'(1);
  assign div_bit = (rem_sh >= dvsr);
  assign rem_sub = div_bit ? (rem_sh - dvsr) : rem_sh;

  always_comb begin
    dvd_we = 1'b0;
    dvs_we = 1'b0;
    waddr  = cnt_r[AW-1:0];
    wdata  = ld_dvd;
    case (cmd.op)
      S_LOAD: begin
        dvd_we = acc && (cnt_r < MAXC);
        dvs_we = acc && (cnt_r < MAXC);
      end
      S_MSUB: begin
        dvd_we = p2_r;
        waddr  = idx2_r;
        wdata  = msub_d[DB-1:0];
      end
      S_SUB: begin
        dvd_we = p1_r;
        waddr  = idx1_r;
        wdata  = sub_d[DB-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dvd_we) dvd_mem[waddr] <= wdata;
    if (dvs_we) dvs_mem[waddr] <= in_divisor_digit;
    dvd_rd_r <= dvd_mem[raddr];
    dvs_rd_r <= dvs_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      slen_r      <= '0;
      q_r         <= '0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_r   <= issue;
      p2_r   <= p1_r && (cmd.op == S_MSUB);
      idx1_r <= iss_pos[AW-1:0];
      idx2_r <= idx1_r;
      prod_r <= {{DB{1'b0}}, dvs_rd_r} * {{DB{1'b0}}, q_r};
      dvd2_r <= dvd_rd_r;
      if (issue) iss_r <= iss_r + LEN_W'(1);
      if (out_acc && out_last_r) cnt_r <= '0;
      case (cmd.op)
        S_LOAD: begin
          if (acc) begin
            if (cnt_r == '0) slen_r <= in_dividend_len;
            if (cnt_r < MAXC) cnt_r <= cnt_r + LEN_W'(1);
            else cnt_r <= OVFC;
            if (in_last_digit) begin
              top_dvd_r <= ld_dvd;
              top_dvs_r <= in_divisor_digit;
            end
          end
        end
        S_EVAL: begin
          q_r   <= '0;
          len_r <= slen_r;
        end
        S_DIV: begin
          if (cmd.first) begin
            q_r    <= top_dvd_r;
            rem_r  <= '0;
            dcnt_r <= '0;
          end else if (dcnt_r != DSTEPS) begin
            q_r    <= {q_r[DB-2:0], div_bit};
            rem_r  <= rem_sub[DB-1:0];
            dcnt_r <= dcnt_r + DCW'(1);
          end
        end
        S_MSUB: begin
          if (cmd.first) begin
            iss_r   <= '0;
            carry_r <= '0;
            bor_r   <= 1'b0;
          end else if (p2_r) begin
            carry_r <= t_sum[2*DB-1:DB];
            bor_r   <= msub_d[DB];
          end
        end
        S_CMP: begin
          if (cmd.first) begin
            iss_r   <= '0;
            ge_r    <= 1'b1;
            dec_r   <= 1'b0;
            found_r <= 1'b0;
            len_r   <= '0;
          end else if (p1_r) begin
            if (!dec_r && (dvd_rd_r != dvs_rd_r)) begin
              dec_r <= 1'b1;
              ge_r  <= (dvd_rd_r > dvs_rd_r);
            end
            if (!found_r && (dvd_rd_r != '0)) begin
              found_r <= 1'b1;
              len_r   <= LEN_W'(idx1_r) + LEN_W'(1);
            end
          end
        end
        S_SUB: begin
          if (cmd.first) begin
            iss_r <= '0;
            bor_r <= 1'b0;
            len_r <= '0;
            q_r   <= q_r + DB'(1);
          end else if (p1_r) begin
            bor_r <= sub_d[DB];
            if (sub_d[DB-1:0] != '0) len_r <= LEN_W'(idx1_r) + LEN_W'(1);
          end
        end
        S_OUT: begin
          if (cmd.first) begin
            k_r    <= '0;
            pend_r <= 1'b1;
          end else begin
            if (pend_r) begin
              pend_r      <= 1'b0;
              out_valid_r <= 1'b1;
              out_quo_r   <= q_r;
              out_rem_r   <= (k_r < len_r) ? dvd_rd_r : '0;
              out_len_r   <= len_r;
              out_err_r   <= 1'b0;
              out_last_r  <= (k_r == cnt_r - LEN_W'(1));
            end
            if (out_acc) begin
              out_valid_r <= 1'b0;
              if (!out_last_r) begin
                k_r    <= k_nxt;
                pend_r <= 1'b1;
              end
            end
          end
        end
        S_ERR: begin
          if (cmd.first) begin
            out_valid_r <= 1'b1;
            out_quo_r   <= '0;
            out_rem_r   <= '0;
            out_len_r   <= '0;
            out_err_r   <= 1'b1;
            out_last_r  <= 1'b1;
          end else if (out_acc) begin
            out_valid_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign st.last_acc   = acc && in_last_digit;
  assign st.bad        = (cnt_r > MAXC) || (slen_r > cnt_r) || (top_dvs_r == DMASK);
  assign st.div_needed = (slen_r == cnt_r) && (top_dvd_r >= top_dvs_r);
  assign st.div_done   = !cmd.first && (dcnt_r == DSTEPS);
  assign st.q_zero     = (q_r == '0);
  assign st.pass_done  = !cmd.first && (iss_r == slen_r) && !p1_r && !p2_r;
  assign st.ge         = ge_r;
  assign st.out_done   = out_acc && out_last_r;

  assign out_valid           = out_valid_r;
  assign out_quotient        = out_quo_r;
  assign out_remainder_digit = out_rem_r;
  assign out_remainder_len   = out_len_r;
  assign out_error           = out_err_r;
  assign out_last_result     = out_last_r;

endmodule

// ===== rtl/bignum_quotient_digit_step_top.sv =====
// ----------------------------------------------------------------------------
// bignum_quotient_digit_step_top: one quotient digit of a long division
// Loads dividend and divisor digits, estimates the quotient digit from the
// top digits, subtracts divisor times estimate, corrects at most once, and
// returns the quotient digit with the trimmed remainder digits.
//
//   channel  direction  handshake          request contents
//   in_      input      in_valid/in_stall  dividend digit, divisor digit,
//                                          dividend length, last digit flag
//   out_     output     out_valid/out_stall quotient, remainder digit,
//                                          remainder length, error, last flag
//
// Each request of a run is taken as soon as it is offered. After the last one
// the block stalls its input through the check phase, the shift-subtract
// divider and up to three passes over the digit memories, then through the
// result phase, which returns one result per loaded digit (or a single
// error result) and waits out any output stall. No clearing pass follows
// reset.
// ----------------------------------------------------------------------------
module bignum_quotient_digit_step_top
  import bqds_pkg::*;
#(
  parameter int MAX_DIGITS = 64,
  parameter int DIGIT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DIGIT_BITS-1:0] in_dividend_digit,
  input  logic [DIGIT_BITS-1:0] in_divisor_digit,
  input  logic [LEN_W-1:0]      in_dividend_len,
  input  logic                  in_last_digit,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIGIT_BITS-1:0] out_quotient,
  output logic [DIGIT_BITS-1:0] out_remainder_digit,
  output logic [LEN_W-1:0]      out_remainder_len,
  output logic                  out_error,
  output logic                  out_last_result
);

  cmd_t    cmd;
  status_t st;

  bqds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  bqds_datapath #(
    .MAX_DIGITS (MAX_DIGITS),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_valid            (in_valid),
    .in_dividend_digit   (in_dividend_digit),
    .in_divisor_digit    (in_divisor_digit),
    .in_dividend_len     (in_dividend_len),
    .in_last_digit       (in_last_digit),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_quotient        (out_quotient),
    .out_remainder_digit (out_remainder_digit),
    .out_remainder_len   (out_remainder_len),
    .out_error           (out_error),
    .out_last_result     (out_last_result)
  );

endmodule

// ===== dv/bignum_quotient_digit_step_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bignum_quotient_digit_step_top_tb: quotient digit step testbench
// Sends runs of dividend/divisor digit requests, predicts the quotient digit
// and the trimmed remainder of each run, and checks every returned digit in
// order. A short directed table covers the corner cases; random runs
// follow. Both channels idle at random outside a steady stretch of runs, and
// the run includes one long receiver hold-off and two full drains.
// ----------------------------------------------------------------------------
module bignum_quotient_digit_step_top_tb;
  import bqds_pkg::*;

  localparam int MAX_DIGITS = 64;
  localparam int DIGIT_BITS = 16;

  typedef struct packed {
    logic [DIGIT_BITS-1:0] quotient;
    logic [DIGIT_BITS-1:0] rem_digit;
    logic [LEN_W-1:0]      rem_len;
    logic                  error;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic [DIGIT_BITS-1:0] dividend_digit;
    logic [DIGIT_BITS-1:0] divisor_digit;
    logic [LEN_W-1:0]      dividend_len;
    logic                  last_digit;
    logic                  typed;
    result_t               want;
  } digit_req_t;

  localparam result_t NO_RES  = '0;
  localparam result_t ERR_RES = '{16'd0, 16'd0, 7'd0, 1'b1, 1'b1};

  localparam int N_DIRECTED = 19;
  localparam digit_req_t DIRECTED [N_DIRECTED] = '{
    '{16'hFFFF, 16'hFFFE, 7'd1, 1'b1, 1'b1, '{16'd1, 16'd1, 7'd1, 1'b0, 1'b1}},
    '{16'h1234, 16'hFFFF, 7'd1, 1'b1, 1'b1, ERR_RES},
    '{16'h0005, 16'h0003, 7'd2, 1'b1, 1'b1, ERR_RES},
    '{16'hFFFF, 16'h0005, 7'd0, 1'b1, 1'b1, '{16'd0, 16'd0, 7'd0, 1'b0, 1'b1}},
    '{16'hFFFF, 16'h0000, 7'd1, 1'b1, 1'b1, '{16'd0, 16'hFFFF, 7'd1, 1'b0, 1'b1}},
    '{16'h0000, 16'h0000, 7'd1, 1'b1, 1'b1, '{16'd1, 16'd0, 7'd0, 1'b0, 1'b1}},
    '{16'h0007, 16'h0003, 7'd1, 1'b0, 1'b0, NO_RES},
    '{16'hFFFF, 16'h0009, 7'd5, 1'b1, 1'b0, NO_RES},
    '{16'h0000, 16'h0000, 7'd2, 1'b0, 1'b0, NO_RES},
    '{16'h0003, 16'h0005, 7'd0, 1'b1, 1'b0, NO_RES},
    '{16'h0000, 16'hFFFF, 7'd3, 1'b0, 1'b0, NO_RES},
    '{16'h0000, 16'hFFFF, 7'd3, 1'b0, 1'b0, NO_RES},
    '{16'h8000, 16'h7FFF, 7'd3, 1'b1, 1'b0, NO_RES},
    '{16'hFFFF, 16'hFFFF, 7'd2, 1'b0, 1'b0, NO_RES},
    '{16'hFFFF, 16'h0000, 7'd2, 1'b1, 1'b0, NO_RES},
    '{16'hAAAA, 16'h5555, 7'd2, 1'b0, 1'b0, NO_RES},
    '{16'h5555, 16'hAAAA, 7'd2, 1'b1, 1'b0, NO_RES},
    '{16'h5555, 16'hAAAA, 7'd2, 1'b0, 1'b0, NO_RES},
    '{16'hAAAA, 16'h5555, 7'd2, 1'b1, 1'b0, NO_RES}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DIGIT_BITS-1:0] in_dividend_digit = '0;
  logic [DIGIT_BITS-1:0] in_divisor_digit = '0;
  logic [LEN_W-1:0]      in_dividend_len = '0;
  logic                  in_last_digit = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DIGIT_BITS-1:0] out_quotient;
  logic [DIGIT_BITS-1:0] out_remainder_digit;
  logic [LEN_W-1:0]      out_remainder_len;
  logic                  out_error;
  logic                  out_last_result;

  logic    drv_typed = 1'b0;
  result_t drv_want = '0;
  logic    steady = 1'b0;
  logic    hold_out = 1'b0;

  logic [DIGIT_BITS-1:0] dvd_mem [MAX_DIGITS];
  logic [DIGIT_BITS-1:0] dvs_mem [MAX_DIGITS];
  int unsigned           digits_taken = 0;
  int unsigned           dvd_len = 0;
  result_t               run_digits [$];
  result_t               pending_digits [$];
  result_t               got;
  result_t               want;
  int                    mismatches = 0;

  bignum_quotient_digit_step_top #(
    .MAX_DIGITS (MAX_DIGITS),
    .DIGIT_BITS (DIGIT_BITS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_dividend_digit   (in_dividend_digit),
    .in_divisor_digit    (in_divisor_digit),
    .in_dividend_len     (in_dividend_len),
    .in_last_digit       (in_last_digit),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_quotient        (out_quotient),
    .out_remainder_digit (out_remainder_digit),
    .out_remainder_len   (out_remainder_len),
    .out_error           (out_error),
    .out_last_result     (out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void quotient_step(input logic [DIGIT_BITS-1:0] dvd,
                                        input logic [DIGIT_BITS-1:0] dvs,
                                        input logic [LEN_W-1:0] len_in,
                                        input logic fin);
    int unsigned           n;
    int unsigned           s;
    int unsigned           len;
    logic [DIGIT_BITS-1:0] q;
    logic [32:0]           acc;
    logic [16:0]           diff;
    logic                  borrow;
    logic                  ge;
    result_t               r;
    run_digits.delete();
    if (digits_taken == 0) dvd_len = 32'(len_in);
    if (digits_taken < MAX_DIGITS) begin
      dvd_mem[digits_taken] = (digits_taken < dvd_len) ? dvd : '0;
      dvs_mem[digits_taken] = dvs;
      digits_taken++;
    end else begin
      digits_taken = MAX_DIGITS + 1;
    end
    if (!fin) return;
    n = digits_taken;
    s = dvd_len;
    digits_taken = 0;
    if (n > MAX_DIGITS || s > n || dvs_mem[n-1] == '1) begin
      run_digits.push_back(ERR_RES);
      return;
    end
    q = '0;
    len = s;
    if (s == n && dvd_mem[s-1] >= dvs_mem[s-1]) begin
      q = DIGIT_BITS'(dvd_mem[s-1] / ({1'b0, dvs_mem[s-1]} + 17'd1));
      if (q != 0) begin
        acc = '0;
        borrow = 1'b0;
        for (int i = 0; i < s; i++) begin
          acc = acc + dvs_mem[i] * q;
          diff = {1'b0, dvd_mem[i]} - {1'b0, acc[15:0]} - borrow;
          dvd_mem[i] = diff[15:0];
          borrow = diff[16];
          acc = acc >> DIGIT_BITS;
        end
      end
      ge = 1'b1;
      for (int i = s - 1; i >= 0; i--) begin
        if (dvd_mem[i] != dvs_mem[i]) begin
          ge = dvd_mem[i] > dvs_mem[i];
          break;
        end
      end
      if (ge) begin
        q = q + 16'd1;
        borrow = 1'b0;
        for (int i = 0; i < s; i++) begin
          diff = {1'b0, dvd_mem[i]} - {1'b0, dvs_mem[i]} - borrow;
          dvd_mem[i] = diff[15:0];
          borrow = diff[16];
        end
      end
      while (len > 0 && dvd_mem[len-1] == 0) len--;
    end
    for (int k = 0; k < n; k++) begin
      r.quotient = q;
      r.rem_digit = (k < len) ? dvd_mem[k] : '0;
      r.rem_len = len[LEN_W-1:0];
      r.error = 1'b0;
      r.last = (k == n - 1);
      run_digits.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      quotient_step(in_dividend_digit, in_divisor_digit, in_dividend_len, in_last_digit);
      if (drv_typed) pending_digits.push_back(drv_want);
      else foreach (run_digits[k]) pending_digits.push_back(run_digits[k]);
    end
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_quotient, out_remainder_digit, out_remainder_len, out_error,
              out_last_result};
      if (pending_digits.size() == 0) begin
        $error("unexpected result: quotient=%h remainder_digit=%h", got.quotient,
               got.rem_digit);
        mismatches++;
      end else begin
        want = pending_digits.pop_front();
        if (got.quotient !== want.quotient) begin
          $error("quotient: expected %h, got %h", want.quotient, got.quotient);
          mismatches++;
        end
        if (got.rem_digit !== want.rem_digit) begin
          $error("remainder_digit: expected %h, got %h", want.rem_digit, got.rem_digit);
          mismatches++;
        end
        if (got.rem_len !== want.rem_len) begin
          $error("remainder_len: expected %0d, got %0d", want.rem_len, got.rem_len);
          mismatches++;
        end
        if (got.error !== want.error) begin
          $error("error: expected %b, got %b", want.error, got.error);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last_result: expected %b, got %b", want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      out_stall <= !steady && ($urandom_range(0, 99) < 32);
    end
  end

  function automatic logic [DIGIT_BITS-1:0] rand_digit();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return DIGIT_BITS'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic send_item(input logic [DIGIT_BITS-1:0] dvd,
                           input logic [DIGIT_BITS-1:0] dvs,
                           input logic [LEN_W-1:0] len_in,
                           input logic fin,
                           input logic typed,
                           input result_t want_in);
    if (!steady) begin
      while ($urandom_range(0, 99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_dividend_digit <= dvd;
    in_divisor_digit <= dvs;
    in_dividend_len <= len_in;
    in_last_digit <= fin;
    drv_typed <= typed;
    drv_want <= want_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("[bignum_quotient_digit_step_top] ERROR");
    $finish;
  end

  initial begin
    int unsigned           n;
    int unsigned           s;
    int unsigned           run;
    int unsigned           sent;
    int unsigned           kind;
    logic [DIGIT_BITS-1:0] dvd_run [MAX_DIGITS+2];
    logic [DIGIT_BITS-1:0] dvs_run [MAX_DIGITS+2];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_item(DIRECTED[i].dividend_digit, DIRECTED[i].divisor_digit,
                DIRECTED[i].dividend_len, DIRECTED[i].last_digit,
                DIRECTED[i].typed, DIRECTED[i].want);

    run = 0;
    sent = 0;
    while (sent < 200) begin
      run++;
      steady = (run >= 15 && run < 25);
      if (run == 5) hold_out = 1'b1;
      if (run == 12) drain();
      if (run == 2) n = MAX_DIGITS;
      else if (run == 6) n = MAX_DIGITS + 2;
      else n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        dvd_run[i] = rand_digit();
        dvs_run[i] = rand_digit();
      end
      kind = (n >= MAX_DIGITS) ? 0 : $urandom_range(0, 99);
      if (kind < 75) begin
        s = n;
        dvs_run[n-1] = DIGIT_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                               : $urandom_range(0, 16'hFFFE));
      end else if (kind < 85) begin
        s = $urandom_range(0, n - 1);
      end else if (kind < 93) begin
        s = n + $urandom_range(1, 4);
      end else begin
        s = n;
        dvs_run[n-1] = '1;
      end
      if (s > MAX_DIGITS) s = MAX_DIGITS;
      if (kind < 75 && s == n)
        dvd_run[s-1] = DIGIT_BITS'($urandom_range(dvs_run[s-1], 16'hFFFF));
      for (int i = 0; i < n; i++)
        send_item(dvd_run[i], dvs_run[i],
                  LEN_W'((i == 0) ? s : $urandom_range(0, MAX_DIGITS)),
                  i == n - 1, 1'b0, NO_RES);
      sent += n;
    end
    steady = 1'b0;

    drain();
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("[bignum_quotient_digit_step_top] OK");
    end else begin
      $display("[bignum_quotient_digit_step_top] ERROR");
    end
    $finish;
  end

endmodule
